>>> hw/rtl/emt_pkg.sv
// Shared types and constants for the endpoint match table.
// Used by the channel interfaces, the controller, the datapath and the top level.
`timescale 1ns / 1ps

package emt_pkg;

   localparam int FUNC_W = 2;
   localparam int ADDR_W = 32;
   localparam int PORT_W = 16;
   localparam int SLOT_W = 3;

   typedef logic [FUNC_W-1:0] func_type;

   localparam func_type FUNC_INSERT = 2'd0;
   localparam func_type FUNC_LOOKUP = 2'd1;
   localparam func_type FUNC_READ   = 2'd2;

   // One stored table entry as it sits in the RAM.
   typedef struct packed {
      logic              main;
      logic [ADDR_W-1:0] addr;
      logic [PORT_W-1:0] port;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // Which result the datapath captures into its staging register.
   typedef enum logic [2:0] {
      STG_NONE,
      STG_INSERT,
      STG_MISS,
      STG_READ,
      STG_HIT
   } stage_type;

   typedef struct packed {
      logic      accept;
      logic      scan_next;
      stage_type stage;
      logic      load_out;
   } cmd_type;

   typedef struct packed {
      logic count_zero;
      logic idx_ok;
      logic match;
      logic scan_last;
   } status_type;

   typedef struct packed {
      logic              ok;
      logic [SLOT_W-1:0] slot;
      logic [ADDR_W-1:0] entry_addr;
      logic [PORT_W-1:0] entry_port;
      logic              entry_main;
      logic              entry_active;
   } res_type;

   typedef struct packed {
      logic              ok;
      logic [SLOT_W-1:0] slot;
      logic [ADDR_W-1:0] entry_addr;
      logic [PORT_W-1:0] entry_port;
      logic [ADDR_W-1:0] host_addr;
      logic [PORT_W-1:0] host_port;
      logic              entry_main;
      logic              entry_active;
      logic [SLOT_W-1:0] main_index;
   } rsp_type;

endpackage

>>> hw/rtl/emt_channels.sv
// Valid/ready channel interfaces for the endpoint match table request and response.
// Depends on emt_pkg for field widths.
`timescale 1ns / 1ps

interface emt_req_if;
   logic                       valid;
   logic                       ready;
   emt_pkg::func_type          func;
   logic [emt_pkg::ADDR_W-1:0] addr;
   logic [emt_pkg::PORT_W-1:0] port_num;
   logic                       is_main;
   logic [emt_pkg::SLOT_W-1:0] entry_index;

   modport source (output valid, func, addr, port_num, is_main, entry_index, input ready);
   modport sink (input valid, func, addr, port_num, is_main, entry_index, output ready);
endinterface

interface emt_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       ok;
   logic [emt_pkg::SLOT_W-1:0] slot;
   logic [emt_pkg::ADDR_W-1:0] entry_addr;
   logic [emt_pkg::PORT_W-1:0] entry_port;
   logic [emt_pkg::ADDR_W-1:0] host_addr;
   logic [emt_pkg::PORT_W-1:0] host_port;
   logic                       entry_main;
   logic                       entry_active;
   logic [emt_pkg::SLOT_W-1:0] main_index;

   modport source (output valid, ok, slot, entry_addr, entry_port, host_addr, host_port,
                   entry_main, entry_active, main_index, input ready);
   modport sink (input valid, ok, slot, entry_addr, entry_port, host_addr, host_port,
                 entry_main, entry_active, main_index, output ready);
endinterface

>>> hw/rtl/emt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module emt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/emt_ctrl.sv
// Controller state machine for the endpoint match table.
// Depends on emt_pkg for the command and status structs.
`timescale 1ns / 1ps

module emt_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  emt_pkg::func_type   req_func,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  emt_pkg::status_type status,
   output emt_pkg::cmd_type    cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_SCAN,
      S_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      cmd.accept    = 1'b0;
      cmd.scan_next = 1'b0;
      cmd.stage     = emt_pkg::STG_NONE;
      cmd.load_out  = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               case (req_func)
                  emt_pkg::FUNC_INSERT: begin
                     cmd.stage = emt_pkg::STG_INSERT;
                     state_in  = S_EMIT;
                  end
                  emt_pkg::FUNC_LOOKUP: begin
                     if (status.count_zero) begin
                        cmd.stage = emt_pkg::STG_MISS;
                        state_in  = S_EMIT;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  emt_pkg::FUNC_READ: begin
                     if (status.idx_ok) begin
                        state_in = S_READ;
                     end else begin
                        cmd.stage = emt_pkg::STG_MISS;
                        state_in  = S_EMIT;
                     end
                  end
                  default: begin
                     cmd.stage = emt_pkg::STG_MISS;
                     state_in  = S_EMIT;
                  end
               endcase
            end
         end
         S_READ: begin
            cmd.stage = emt_pkg::STG_READ;
            state_in  = S_EMIT;
         end
         S_SCAN: begin
            if (status.match) begin
               cmd.stage = emt_pkg::STG_HIT;
               state_in  = S_EMIT;
            end else if (status.scan_last) begin
               cmd.stage = emt_pkg::STG_MISS;
               state_in  = S_EMIT;
            end else begin
               cmd.scan_next = 1'b1;
            end
         end
         S_EMIT: begin
            // move the staged word out once the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

>>> hw/rtl/emt_dp.sv
// Datapath for the endpoint match table: entry RAM, fill count, main tracker,
// scan counter, staging and output registers. Depends on emt_pkg and emt_ram.
`timescale 1ns / 1ps

module emt_dp #(
   parameter int TABLE_ENTRIES = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  emt_pkg::cmd_type           cmd,
   output emt_pkg::status_type        status,
   input  emt_pkg::func_type          req_func,
   input  logic [emt_pkg::ADDR_W-1:0] req_addr,
   input  logic [emt_pkg::PORT_W-1:0] req_port_num,
   input  logic                       req_is_main,
   input  logic [emt_pkg::SLOT_W-1:0] req_entry_index,
   output emt_pkg::rsp_type           rsp_word
);

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

   logic [CNT_W-1:0]           count_ff, count_in;
   logic                       main_found_ff, main_found_in;
   logic [emt_pkg::SLOT_W-1:0] main_idx_ff, main_idx_in;
   logic [IDX_W-1:0]           scan_ff, scan_in;
   logic [CNT_W-1:0]           scan_next_cnt;
   logic [emt_pkg::ADDR_W-1:0] key_addr_ff, key_addr_in;
   logic [emt_pkg::PORT_W-1:0] key_port_ff, key_port_in;
   logic [emt_pkg::SLOT_W-1:0] rd_slot_ff, rd_slot_in;
   logic                       rd_active_ff, rd_active_in;
   emt_pkg::res_type           stage_ff, stage_in;
   emt_pkg::rsp_type           out_ff, out_in;

   logic                       full;
   logic                       ins_ok;
   logic [IDX_W-1:0]           rd_addr;
   logic [emt_pkg::ENTRY_W-1:0] rd_data;
   emt_pkg::entry_type         rd_entry;
   emt_pkg::entry_type         wr_entry;

   function automatic logic [31:0] swap32(input logic [31:0] v);
      return {v[7:0], v[15:8], v[23:16], v[31:24]};
   endfunction

   function automatic logic [15:0] swap16(input logic [15:0] v);
      return {v[7:0], v[15:8]};
   endfunction

   assign full          = (count_ff == CNT_W'(TABLE_ENTRIES));
   assign ins_ok        = (cmd.stage == emt_pkg::STG_INSERT) && !full;
   assign scan_next_cnt = CNT_W'(scan_ff) + CNT_W'(1);
   assign rd_entry      = emt_pkg::entry_type'(rd_data);

   assign wr_entry.main = req_is_main;
   assign wr_entry.addr = req_addr;
   assign wr_entry.port = req_port_num;

   // entries fill in index order and are never freed, so the count marks the active prefix
   always_comb begin
      if (cmd.accept) begin
         rd_addr = (req_func == emt_pkg::FUNC_LOOKUP) ? '0 : IDX_W'(req_entry_index);
      end else begin
         rd_addr = IDX_W'(scan_next_cnt);
      end
   end

   emt_ram #(
      .WIDTH (emt_pkg::ENTRY_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ins_ok),
      .wr_addr (IDX_W'(count_ff)),
      .wr_data (wr_entry),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign status.count_zero = (count_ff == '0);
   assign status.idx_ok     = (32'(req_entry_index) < 32'(TABLE_ENTRIES));
   assign status.match      = (rd_entry.addr == key_addr_ff) && (rd_entry.port == key_port_ff);
   assign status.scan_last  = (scan_next_cnt == count_ff);

   always_comb begin
      count_in      = count_ff;
      main_found_in = main_found_ff;
      main_idx_in   = main_idx_ff;
      scan_in       = scan_ff;
      key_addr_in   = key_addr_ff;
      key_port_in   = key_port_ff;
      rd_slot_in    = rd_slot_ff;
      rd_active_in  = rd_active_ff;
      stage_in      = stage_ff;
      out_in        = out_ff;

      if (cmd.accept) begin
         key_addr_in  = req_addr;
         key_port_in  = req_port_num;
         rd_slot_in   = req_entry_index;
         rd_active_in = (32'(req_entry_index) < 32'(count_ff));
         scan_in      = '0;
      end
      if (cmd.scan_next) begin
         scan_in = IDX_W'(scan_next_cnt);
      end

      if (ins_ok) begin
         count_in = count_ff + CNT_W'(1);
         // later inserts land higher, so the first main insert stays the lowest
         if (req_is_main && !main_found_ff) begin
            main_found_in = 1'b1;
            main_idx_in   = emt_pkg::SLOT_W'(count_ff);
         end
      end

      case (cmd.stage)
         emt_pkg::STG_NONE: begin
            stage_in = stage_ff;
         end
         emt_pkg::STG_INSERT: begin
            if (full) begin
               stage_in = '0;
            end else begin
               stage_in.ok           = 1'b1;
               stage_in.slot         = emt_pkg::SLOT_W'(count_ff);
               stage_in.entry_addr   = req_addr;
               stage_in.entry_port   = req_port_num;
               stage_in.entry_main   = req_is_main;
               stage_in.entry_active = 1'b1;
            end
         end
         emt_pkg::STG_MISS: begin
            stage_in = '0;
         end
         emt_pkg::STG_READ: begin
            // unwritten entries read as zero
            stage_in.ok           = 1'b1;
            stage_in.slot         = rd_slot_ff;
            stage_in.entry_addr   = rd_active_ff ? rd_entry.addr : '0;
            stage_in.entry_port   = rd_active_ff ? rd_entry.port : '0;
            stage_in.entry_main   = rd_active_ff && rd_entry.main;
            stage_in.entry_active = rd_active_ff;
         end
         emt_pkg::STG_HIT: begin
            stage_in.ok           = 1'b1;
            stage_in.slot         = emt_pkg::SLOT_W'(scan_ff);
            stage_in.entry_addr   = rd_entry.addr;
            stage_in.entry_port   = rd_entry.port;
            stage_in.entry_main   = rd_entry.main;
            stage_in.entry_active = 1'b1;
         end
         default: begin
            stage_in = '0;
         end
      endcase

      if (cmd.load_out) begin
         out_in.ok           = stage_ff.ok;
         out_in.slot         = stage_ff.slot;
         out_in.entry_addr   = stage_ff.entry_addr;
         out_in.entry_port   = stage_ff.entry_port;
         out_in.host_addr    = swap32(stage_ff.entry_addr);
         out_in.host_port    = swap16(stage_ff.entry_port);
         out_in.entry_main   = stage_ff.entry_main;
         out_in.entry_active = stage_ff.entry_active;
         out_in.main_index   = main_idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         main_found_ff <= 1'b0;
         main_idx_ff   <= '0;
         scan_ff       <= '0;
      end else begin
         count_ff      <= count_in;
         main_found_ff <= main_found_in;
         main_idx_ff   <= main_idx_in;
         scan_ff       <= scan_in;
      end
   end

   always_ff @(posedge clock) begin
      key_addr_ff  <= key_addr_in;
      key_port_ff  <= key_port_in;
      rd_slot_ff   <= rd_slot_in;
      rd_active_ff <= rd_active_in;
      stage_ff     <= stage_in;
      out_ff       <= out_in;
   end

   assign rsp_word = out_ff;

endmodule

>>> hw/rtl/endpoint_match_table.sv
// Top level of the endpoint match table: controller plus datapath.
// Depends on emt_pkg, emt_channels, emt_ram, emt_ctrl and emt_dp.
//
//   channel   dir  handshake      word
//   req_chan  in   valid/ready    func, addr, port_num, is_main, entry_index
//   rsp_chan  out  valid/ready    ok, slot, entry/host addr and port, flags, main_index
//
// A lookup examines at most the fill count of entries, walking the single read port
// of the entry RAM one entry per cycle.
// Reset clears the fill count and main tracker; RAM contents are not cleared, and
// entries past the fill count read as zero. A result waits in the output register
// while the next word is taken; a second result holds until the first is taken.
`timescale 1ns / 1ps

module endpoint_match_table #(
   parameter int TABLE_ENTRIES = 8
) (
   input  logic       clock,
   input  logic       reset,
   emt_req_if.sink    req_chan,
   emt_rsp_if.source  rsp_chan
);

   emt_pkg::cmd_type    cmd;
   emt_pkg::status_type status;
   emt_pkg::rsp_type    rsp_word;

   emt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_func  (req_chan.func),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   emt_dp #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_func        (req_chan.func),
      .req_addr        (req_chan.addr),
      .req_port_num    (req_chan.port_num),
      .req_is_main     (req_chan.is_main),
      .req_entry_index (req_chan.entry_index),
      .rsp_word        (rsp_word)
   );

   assign rsp_chan.ok           = rsp_word.ok;
   assign rsp_chan.slot         = rsp_word.slot;
   assign rsp_chan.entry_addr   = rsp_word.entry_addr;
   assign rsp_chan.entry_port   = rsp_word.entry_port;
   assign rsp_chan.host_addr    = rsp_word.host_addr;
   assign rsp_chan.host_port    = rsp_word.host_port;
   assign rsp_chan.entry_main   = rsp_word.entry_main;
   assign rsp_chan.entry_active = rsp_word.entry_active;
   assign rsp_chan.main_index   = rsp_word.main_index;

endmodule

>>> test/emt_table_checker.sv
// Checker for the endpoint match table: watches both channels, predicts each response
// word from a private copy of the table and compares it field by field.
// Depends on emt_pkg and the channel interfaces in emt_channels.
`timescale 1ns / 1ps

module emt_table_checker #(
   parameter int TABLE_ENTRIES = 8
) (
   input  logic clock,
   input  logic reset,
   emt_req_if   req,
   emt_rsp_if   rsp,
   output int   errors,
   output int   pending
);

   logic                       shadow_active [TABLE_ENTRIES];
   logic                       shadow_main   [TABLE_ENTRIES];
   logic [emt_pkg::ADDR_W-1:0] shadow_addr   [TABLE_ENTRIES];
   logic [emt_pkg::PORT_W-1:0] shadow_port   [TABLE_ENTRIES];

   emt_pkg::rsp_type expected_words [$];
   emt_pkg::rsp_type want;

   // Apply one request to the shadow table and return the response it should produce.
   function automatic emt_pkg::rsp_type resolve_request(emt_pkg::func_type f,
                                                        logic [emt_pkg::ADDR_W-1:0] a,
                                                        logic [emt_pkg::PORT_W-1:0] p,
                                                        logic m,
                                                        logic [emt_pkg::SLOT_W-1:0] idx);
      emt_pkg::rsp_type r;
      int               hit;
      r   = '0;
      hit = -1;
      case (f)
         emt_pkg::FUNC_INSERT: begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
               if (hit < 0 && !shadow_active[i]) begin
                  shadow_active[i] = 1'b1;
                  shadow_main[i]   = m;
                  shadow_addr[i]   = a;
                  shadow_port[i]   = p;
                  hit = i;
               end
            end
         end
         emt_pkg::FUNC_LOOKUP: begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
               if (hit < 0 && shadow_active[i] && shadow_addr[i] == a && shadow_port[i] == p)
                  hit = i;
            end
         end
         emt_pkg::FUNC_READ: begin
            if (int'(idx) < TABLE_ENTRIES) hit = int'(idx);
         end
         default: ;
      endcase
      if (hit >= 0) begin
         r.ok           = 1'b1;
         r.slot         = emt_pkg::SLOT_W'(hit);
         r.entry_addr   = shadow_addr[hit];
         r.entry_port   = shadow_port[hit];
         r.host_addr    = {shadow_addr[hit][7:0], shadow_addr[hit][15:8],
                           shadow_addr[hit][23:16], shadow_addr[hit][31:24]};
         r.host_port    = {shadow_port[hit][7:0], shadow_port[hit][15:8]};
         r.entry_main   = shadow_main[hit];
         r.entry_active = shadow_active[hit];
      end
      // walk downward so the lowest active main entry wins
      for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
         if (shadow_active[i] && shadow_main[i]) r.main_index = emt_pkg::SLOT_W'(i);
      end
      return r;
   endfunction

   task automatic compare_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
      if (exp_val !== act_val) begin
         errors++;
         $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, exp_val, act_val);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            shadow_active[i] = 1'b0;
            shadow_main[i]   = 1'b0;
            shadow_addr[i]   = '0;
            shadow_port[i]   = '0;
         end
         expected_words.delete();
         errors = 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (expected_words.size() == 0) begin
               errors++;
               $display("%0t ns: response word with nothing expected, expected none, got %h",
                        $time, rsp.entry_addr);
            end else begin
               want = expected_words.pop_front();
               compare_field("ok",           32'(want.ok),           32'(rsp.ok));
               compare_field("slot",         32'(want.slot),         32'(rsp.slot));
               compare_field("entry_addr",   want.entry_addr,        rsp.entry_addr);
               compare_field("entry_port",   32'(want.entry_port),   32'(rsp.entry_port));
               compare_field("host_addr",    want.host_addr,         rsp.host_addr);
               compare_field("host_port",    32'(want.host_port),    32'(rsp.host_port));
               compare_field("entry_main",   32'(want.entry_main),   32'(rsp.entry_main));
               compare_field("entry_active", 32'(want.entry_active), 32'(rsp.entry_active));
               compare_field("main_index",   32'(want.main_index),   32'(rsp.main_index));
            end
         end
         if (req.valid && req.ready)
            expected_words.push_back(resolve_request(req.func, req.addr, req.port_num,
                                                     req.is_main, req.entry_index));
      end
      pending <= expected_words.size();
   end

endmodule

>>> test/tb.sv
// Top of the endpoint match table testbench: clock, reset, request and response traffic.
// Depends on emt_pkg, emt_channels, endpoint_match_table and emt_table_checker.
`timescale 1ns / 1ps

module tb;

   localparam int                RANDOM_WORDS = 1200;
   localparam int                CYCLE_LIMIT  = 200000;
   localparam emt_pkg::func_type FUNC_SPARE   = 2'd3;

   logic clock;
   logic reset;
   int   mismatches;
   int   outstanding;
   int   cycles;
   int   words_sent;
   bit   calm;
   bit   held_off;

   logic [emt_pkg::ADDR_W-1:0] seen_addr [$];
   logic [emt_pkg::PORT_W-1:0] seen_port [$];

   emt_req_if req_chan ();
   emt_rsp_if rsp_chan ();

   endpoint_match_table dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   emt_table_checker table_check (
      .clock   (clock),
      .reset   (reset),
      .req     (req_chan),
      .rsp     (rsp_chan),
      .errors  (mismatches),
      .pending (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Offer one request word, idling first at random, and hold it until taken.
   task automatic send_word(emt_pkg::func_type f, logic [emt_pkg::ADDR_W-1:0] a,
                            logic [emt_pkg::PORT_W-1:0] p, logic m,
                            logic [emt_pkg::SLOT_W-1:0] idx);
      while (!calm && $urandom_range(99) < 32) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.func        <= f;
      req_chan.addr        <= a;
      req_chan.port_num    <= p;
      req_chan.is_main     <= m;
      req_chan.entry_index <= idx;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      if (f == emt_pkg::FUNC_INSERT) begin
         seen_addr.push_back(a);
         seen_port.push_back(p);
      end
      words_sent++;
   endtask

   // Response side: random stalls, one long hold-off while requests keep coming.
   initial begin
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!held_off && words_sent >= 300) begin
            rsp_chan.ready <= 1'b0;
            repeat (200) @(posedge clock);
            held_off = 1'b1;
         end else begin
            rsp_chan.ready <= calm || ($urandom_range(99) >= 32);
            @(posedge clock);
         end
      end
   end

   initial begin
      emt_pkg::func_type          f;
      logic [emt_pkg::ADDR_W-1:0] a;
      logic [emt_pkg::PORT_W-1:0] p;
      int                         r;
      int                         pick;
      int                         bitpos;

      reset                <= 1'b1;
      req_chan.valid       <= 1'b0;
      req_chan.func        <= emt_pkg::FUNC_INSERT;
      req_chan.addr        <= '0;
      req_chan.port_num    <= '0;
      req_chan.is_main     <= 1'b0;
      req_chan.entry_index <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty table, extremes, duplicates, main tracking
      send_word(FUNC_SPARE,           '1, '1, 1'b1, '1);
      send_word(emt_pkg::FUNC_READ,   '0, '0, 1'b0, 3'd0);
      send_word(emt_pkg::FUNC_READ,   '0, '0, 1'b0, 3'd7);
      send_word(emt_pkg::FUNC_LOOKUP, '0, '0, 1'b0, 3'd0);
      send_word(emt_pkg::FUNC_INSERT, '0, '0, 1'b0, 3'd0);
      send_word(emt_pkg::FUNC_LOOKUP, '0, '0, 1'b0, 3'd0);
      send_word(emt_pkg::FUNC_INSERT, '1, '1, 1'b1, 3'd0);
      send_word(emt_pkg::FUNC_INSERT, '1, '1, 1'b0, 3'd0);
      send_word(emt_pkg::FUNC_LOOKUP, '1, '1, 1'b0, 3'd0);
      send_word(emt_pkg::FUNC_LOOKUP, '1, 16'hFFFE, 1'b0, 3'd0);
      send_word(emt_pkg::FUNC_READ,   '0, '0, 1'b0, 3'd1);
      send_word(emt_pkg::FUNC_READ,   '0, '0, 1'b0, 3'd2);
      send_word(emt_pkg::FUNC_READ,   '1, '1, 1'b1, 3'd3);
      send_word(emt_pkg::FUNC_INSERT, 32'h1234_5678, 16'hABCD, 1'b1, 3'd0);
      send_word(emt_pkg::FUNC_LOOKUP, 32'h1234_5678, 16'hABCD, 1'b0, 3'd7);
      send_word(FUNC_SPARE,           '0, '0, 1'b0, '0);

      // random: mostly lookups that hit or nearly hit, sparse inserts so the table
      // stays partly filled for a while before it saturates
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         calm = (n >= 700 && n < 900);
         r    = $urandom_range(999);
         a    = $urandom;
         p    = emt_pkg::PORT_W'($urandom_range(65535));
         pick = $urandom_range(seen_addr.size() - 1);
         if (r < 15) begin
            f = emt_pkg::FUNC_INSERT;
            if ($urandom_range(2) == 0) begin
               a = seen_addr[pick];
               p = seen_port[pick];
            end
         end else if (r < 250) begin
            f = emt_pkg::FUNC_READ;
         end else if (r < 300) begin
            f = FUNC_SPARE;
         end else begin
            f = emt_pkg::FUNC_LOOKUP;
            r = $urandom_range(99);
            if (r < 85) begin
               a = seen_addr[pick];
               p = seen_port[pick];
            end
            // flip one bit for a near miss
            if (r >= 65 && r < 85) begin
               bitpos = $urandom_range(emt_pkg::ADDR_W + emt_pkg::PORT_W - 1);
               if (bitpos < emt_pkg::ADDR_W) a[bitpos] = ~a[bitpos];
               else p[bitpos - emt_pkg::ADDR_W] = ~p[bitpos - emt_pkg::ADDR_W];
            end
         end
         send_word(f, a, p, 1'($urandom_range(1)), 3'($urandom_range(7)));
      end
      calm = 1'b0;
      req_chan.valid <= 1'b0;

      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
